>>> rtl/sfa_pkg.sv
// Shared types, constants and arctangent table for the smoothed field angle block.
package sfa_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int STEP_W       = $clog2(ATAN_ENTRIES);

  localparam logic [31:0] HALF_TURN       = 32'h8000_0000;
  localparam logic [11:0] TENTHS_PER_TURN = 12'd3600;
  localparam logic [11:0] ANGLE_MAX       = 12'd3599;
  localparam logic [11:0] ANGLE_0         = 12'd0;
  localparam logic [11:0] ANGLE_90        = 12'd900;
  localparam logic [11:0] ANGLE_180       = 12'd1800;
  localparam logic [11:0] ANGLE_270       = 12'd2700;
  localparam logic [15:0] MIN_MAG_RESET   = 16'd16;

  typedef struct packed {
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
  } sample_t;

  typedef struct packed {
    logic [11:0] angle_tenths;
    logic        held;
  } result_t;

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2FA;
      5'd15:   v = 32'h0000_517D;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A30;
      5'd19:   v = 32'h0000_0518;
      5'd20:   v = 32'h0000_028C;
      5'd21:   v = 32'h0000_0146;
      5'd22:   v = 32'h0000_00A3;
      5'd23:   v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/smoothed_field_angle.sv
// Top level: smoothing, magnitude gate and angle sequencer for magnetic field samples.
//
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one field
//   request: signed x and y. sample_stall is high whenever a request is in work;
//   the block takes one request at a time.
//   result channel (result_valid / result_stall / result) returns one angle in
//   tenths of a degree and a held flag for every request.
//   cfg_we / cfg_wdata write min_magnitude_sq; write only while idle.
// Sequence:
//   an accepted request is averaged (S_AVG), its squared magnitude is formed
//   (S_MAG, S_MAG_WAIT), and a held result goes straight to S_OUT.
//   A computed result passes through the CORDIC loop (S_ROT, S_ROT_WAIT),
//   which retires one iteration per cycle with separate add/sub for x, y and phase.
//   Axis vectors skip the loop.
//   The next request can be taken in the cycle after the result is delivered.
// Reset (rst, synchronous): averages unseeded, no stored angle, threshold 16.
// Stall: a result held by result_stall stays stable; no new request is
//   taken until it has been delivered.
module smoothed_field_angle #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  sfa_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output sfa_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);

  localparam int STEPS = (CORDIC_STEPS > sfa_pkg::ATAN_ENTRIES) ?
                         sfa_pkg::ATAN_ENTRIES : CORDIC_STEPS;

  typedef enum logic [2:0] {S_IDLE, S_AVG, S_MAG, S_MAG_WAIT, S_ROT, S_ROT_WAIT, S_OUT} state_t;

  state_t             state;
  logic signed [15:0] in_x;
  logic signed [15:0] in_y;
  logic signed [15:0] avg_x;
  logic signed [15:0] avg_y;
  logic               seeded;
  logic [11:0]        last_angle;
  logic               last_angle_valid;
  logic [15:0]        min_magnitude_sq;

  logic signed [15:0] avg_x_next;
  logic signed [15:0] avg_y_next;
  logic               mag_done;
  logic [31:0]        mag;
  logic               rot_done;
  logic [11:0]        rot_angle;

  function automatic logic signed [15:0] smooth(input logic signed [15:0] prev,
                                                input logic signed [15:0] cur);
    logic signed [17:0] base;
    logic signed [17:0] sum;
    logic signed [17:0] adj;
    base = {{2{prev[15]}}, prev};
    sum  = (base <<< 1) + base + {{2{cur[15]}}, cur};
    adj  = sum + (sum[17] ? 18'sd3 : 18'sd0);
    return adj[17:2];
  endfunction

  assign avg_x_next   = smooth(seeded ? avg_x : in_x, in_x);
  assign avg_y_next   = smooth(seeded ? avg_y : in_y, in_y);
  assign sample_stall = (state != S_IDLE);
  assign result_valid = (state == S_OUT);

  sfa_mag u_mag (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_MAG),
    .a     (avg_x),
    .b     (avg_y),
    .done  (mag_done),
    .mag   (mag)
  );

  sfa_cordic #(.STEPS(STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_ROT),
    .x     (avg_x),
    .y     (avg_y),
    .done  (rot_done),
    .angle (rot_angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      avg_x            <= 16'sd0;
      avg_y            <= 16'sd0;
      seeded           <= 1'b0;
      last_angle       <= 12'd0;
      last_angle_valid <= 1'b0;
      min_magnitude_sq <= sfa_pkg::MIN_MAG_RESET;
    end else begin
      if (cfg_we) min_magnitude_sq <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            in_x  <= sample.field_x;
            in_y  <= sample.field_y;
            state <= S_AVG;
          end
        end
        S_AVG: begin
          avg_x  <= avg_x_next;
          avg_y  <= avg_y_next;
          seeded <= 1'b1;
          state  <= S_MAG;
        end
        S_MAG: state <= S_MAG_WAIT;
        S_MAG_WAIT: begin
          if (mag_done) begin
            if ((mag < {16'd0, min_magnitude_sq}) && last_angle_valid) begin
              result.angle_tenths <= last_angle;
              result.held         <= 1'b1;
              state               <= S_OUT;
            end else begin
              state <= S_ROT;
            end
          end
        end
        S_ROT: state <= S_ROT_WAIT;
        S_ROT_WAIT: begin
          if (rot_done) begin
            last_angle          <= rot_angle;
            last_angle_valid    <= 1'b1;
            result.angle_tenths <= rot_angle;
            result.held         <= 1'b0;
            state               <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/sfa_mag.sv
// Squared magnitude of the averaged vector, squaring a and then b on one shared squarer.
module sfa_mag (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic               done,
  output logic [31:0]        mag
);

  logic signed [15:0] op_a;
  logic signed [15:0] op_b;
  logic [1:0]         step;
  logic signed [15:0] operand;
  logic signed [31:0] square;

  assign operand = (step == 2'd1) ? op_a : op_b;
  assign square  = operand * operand;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (step)
        2'd0: begin
          if (start) begin
            op_a <= a;
            op_b <= b;
            step <= 2'd1;
          end
        end
        2'd1: begin
          mag  <= 32'(unsigned'(square));
          step <= 2'd2;
        end
        2'd2: begin
          mag  <= mag + 32'(unsigned'(square));
          done <= 1'b1;
          step <= 2'd0;
        end
        default: step <= 2'd0;
      endcase
    end
  end

endmodule

>>> rtl/sfa_cordic.sv
// Iterative vectoring CORDIC: atan2 of a 16-bit vector in tenths of a degree.
module sfa_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  output logic               done,
  output logic [11:0]        angle
);

  localparam int SW = sfa_pkg::STEP_W;

  typedef enum logic [1:0] {C_IDLE, C_ROT, C_SCALE, C_SAT} cstate_t;

  cstate_t            state;
  logic signed [35:0] cx;
  logic signed [35:0] cy;
  logic [31:0]        phase;
  logic [SW-1:0]      cnt;
  logic [43:0]        prod;
  logic signed [35:0] sx;
  logic signed [35:0] sy;
  logic signed [35:0] x_wide;
  logic signed [35:0] y_wide;
  logic [31:0]        turn;

  assign sx     = cx >>> cnt;
  assign sy     = cy >>> cnt;
  assign x_wide = {{4{x[15]}}, x, 16'b0};
  assign y_wide = {{4{y[15]}}, y, 16'b0};
  assign turn   = sfa_pkg::atan_turn(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            if (y == 16'sd0) begin
              angle <= x[15] ? sfa_pkg::ANGLE_180 : sfa_pkg::ANGLE_0;
              done  <= 1'b1;
            end else if (x == 16'sd0) begin
              angle <= y[15] ? sfa_pkg::ANGLE_270 : sfa_pkg::ANGLE_90;
              done  <= 1'b1;
            end else begin
              cnt <= '0;
              if (x[15]) begin
                cx    <= -x_wide;
                cy    <= -y_wide;
                phase <= sfa_pkg::HALF_TURN;
              end else begin
                cx    <= x_wide;
                cy    <= y_wide;
                phase <= 32'd0;
              end
              state <= C_ROT;
            end
          end
        end
        C_ROT: begin
          if (cy > 36'sd0) begin
            cx    <= cx + sy;
            cy    <= cy - sx;
            phase <= phase + turn;
          end else begin
            cx    <= cx - sy;
            cy    <= cy + sx;
            phase <= phase - turn;
          end
          cnt <= cnt + 1'b1;
          if (cnt == SW'(STEPS - 1)) state <= C_SCALE;
        end
        C_SCALE: begin
          prod  <= 44'(phase) * 44'(sfa_pkg::TENTHS_PER_TURN);
          state <= C_SAT;
        end
        C_SAT: begin
          angle <= (prod[43:32] > sfa_pkg::ANGLE_MAX) ? sfa_pkg::ANGLE_MAX : prod[43:32];
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

>>> verif/sfa_angle_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the smoothed field angle block: predicts every angle request and checks results.
module sfa_angle_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  input  logic             sample_stall,
  input  sfa_pkg::sample_t sample,
  input  logic             result_valid,
  input  logic             result_stall,
  input  sfa_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata,
  output int               errors,
  output int               pending,
  output int               samples_seen,
  output int               held_seen
);

  // atan(2^-i) in turns, 2^32 per turn
  logic [31:0] atan_step_turns [sfa_pkg::ATAN_ENTRIES] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  int               avg_x;
  int               avg_y;
  bit               seeded;
  logic [11:0]      last_angle;
  bit               last_valid;
  logic [15:0]      min_mag_sq;
  sfa_pkg::result_t angles_due [$];
  int               fail_count;
  int               sample_count;
  int               held_count;
  sfa_pkg::result_t want;

  function automatic logic [11:0] field_angle(input int x, input int y);
    longint            cx;
    longint            cy;
    longint            nx;
    longint            ny;
    logic [31:0]       phase;
    longint unsigned   scaled;
    int                steps;
    int                i;
    if (y == 0) begin
      return (x >= 0) ? sfa_pkg::ANGLE_0 : sfa_pkg::ANGLE_180;
    end
    if (x == 0) begin
      return (y > 0) ? sfa_pkg::ANGLE_90 : sfa_pkg::ANGLE_270;
    end
    cx = longint'(x) * 65536;
    cy = longint'(y) * 65536;
    phase = '0;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      phase = sfa_pkg::HALF_TURN;
    end
    steps = (CORDIC_STEPS > sfa_pkg::ATAN_ENTRIES) ? sfa_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    for (i = 0; i < steps; i++) begin
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        phase = phase + atan_step_turns[i];
      end else begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        phase = phase - atan_step_turns[i];
      end
      cx = nx;
      cy = ny;
    end
    scaled = (longint'({32'b0, phase}) * longint'(sfa_pkg::TENTHS_PER_TURN)) >> 32;
    if (scaled > longint'(sfa_pkg::ANGLE_MAX)) begin
      scaled = longint'(sfa_pkg::ANGLE_MAX);
    end
    return scaled[11:0];
  endfunction

  function automatic sfa_pkg::result_t angle_for_sample(input sfa_pkg::sample_t s);
    int               x;
    int               y;
    longint           mag;
    sfa_pkg::result_t r;
    x = s.field_x;
    y = s.field_y;
    if (!seeded) begin
      avg_x = x;
      avg_y = y;
      seeded = 1'b1;
    end
    avg_x = (avg_x * 3 + x) / 4;
    avg_y = (avg_y * 3 + y) / 4;
    mag = longint'(avg_x) * avg_x + longint'(avg_y) * avg_y;
    if (mag < longint'(min_mag_sq) && last_valid) begin
      r.angle_tenths = last_angle;
      r.held = 1'b1;
    end else begin
      last_angle = field_angle(avg_x, avg_y);
      last_valid = 1'b1;
      r.angle_tenths = last_angle;
      r.held = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      avg_x = 0;
      avg_y = 0;
      seeded = 1'b0;
      last_angle = '0;
      last_valid = 1'b0;
      min_mag_sq = sfa_pkg::MIN_MAG_RESET;
      angles_due.delete();
    end else begin
      if (cfg_we) begin
        min_mag_sq = cfg_wdata;
      end
      if (result_valid && !result_stall) begin
        if (angles_due.size() == 0) begin
          $error("unexpected result: angle_tenths %0d held %0d",
                 result.angle_tenths, result.held);
          fail_count++;
        end else begin
          want = angles_due.pop_front();
          if (result.angle_tenths !== want.angle_tenths) begin
            $error("angle_tenths: expected %0d, got %0d",
                   want.angle_tenths, result.angle_tenths);
            fail_count++;
          end
          if (result.held !== want.held) begin
            $error("held: expected %0d, got %0d", want.held, result.held);
            fail_count++;
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        want = angle_for_sample(sample);
        angles_due.push_back(want);
        sample_count++;
        if (want.held) begin
          held_count++;
        end
      end
    end
    pending      <= angles_due.size();
    errors       <= fail_count;
    samples_seen <= sample_count;
    held_seen    <= held_count;
  end

endmodule

>>> verif/tb_smoothed_field_angle.sv
`timescale 1ns / 100ps
// Testbench top for the smoothed field angle block: stimulus, stalls, watchdog and verdict.
module tb_smoothed_field_angle;

  localparam int STEPS      = 16;
  localparam int MAX_WAIT   = 17;
  localparam int HANG_LIMIT = 2000;
  localparam int TAIL       = 40;
  localparam int PHASE_LEN  = 180;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             sample_valid = 1'b0;
  logic             sample_stall;
  sfa_pkg::sample_t sample = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  sfa_pkg::result_t result;
  logic             cfg_we = 1'b0;
  logic [15:0]      cfg_wdata = '0;

  int errors;
  int pending;
  int samples_seen;
  int held_seen;
  int idle_cycles = 0;
  int trk_x;
  int trk_y;
  bit trk_seeded = 1'b0;
  int send_burst = 0;
  int recv_burst = 0;
  int settings = 1;

  always #5 clk = ~clk;

  smoothed_field_angle #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  sfa_angle_checker #(
    .CORDIC_STEPS(STEPS)
  ) angle_chk (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .pending     (pending),
    .samples_seen(samples_seen),
    .held_seen   (held_seen)
  );

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic pick_wait(inout int burst, output int n);
    if (burst > 0) begin
      burst--;
      n = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(8, 40);
      n = 0;
    end else begin
      n = $urandom_range(0, MAX_WAIT);
    end
  endtask

  task automatic send_sample(input int x, input int y);
    int n;
    sample <= {x[15:0], y[15:0]};
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    if (!trk_seeded) begin
      trk_x = x;
      trk_y = y;
      trk_seeded = 1'b1;
    end
    trk_x = (3 * trk_x + x) / 4;
    trk_y = (3 * trk_y + y) / 4;
    pick_wait(send_burst, n);
    if (n > 0) begin
      sample_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drive the running average onto (tx, ty) in as few requests as the input range allows
  task automatic steer(input int tx, input int ty);
    int x;
    int y;
    int tries;
    tries = 0;
    do begin
      x = trk_seeded ? clamp16(4 * tx - 3 * trk_x) : tx;
      y = trk_seeded ? clamp16(4 * ty - 3 * trk_y) : ty;
      send_sample(x, y);
      tries++;
    end while ((trk_x != tx || trk_y != ty) && tries < 6);
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_sample();
    int t;
    case ($urandom_range(0, 5))
      0, 1: send_sample(int'($urandom_range(0, 65535)) - 32768,
                        int'($urandom_range(0, 65535)) - 32768);
      2: send_sample(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300);
      3: begin
        t = int'($urandom_range(0, 4000)) - 2000;
        if ($urandom_range(0, 1) == 0) steer(t, 0);
        else steer(0, t);
      end
      4: steer(int'($urandom_range(0, 80)) - 40, int'($urandom_range(0, 80)) - 40);
      default: send_sample(clamp16(-trk_x), clamp16(trk_y));
    endcase
  endtask

  initial begin
    int n;
    forever begin
      pick_wait(recv_burst, n);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  initial begin
    logic [15:0] thr;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero vector before any angle, then held
    steer(0, 0);
    steer(0, 0);
    // axes
    steer(1000, 0);
    steer(0, 1000);
    steer(-1000, 0);
    steer(0, -1000);
    // just below the wrap, negative x on both sides of the half turn
    steer(1000, -1);
    steer(-1000, -1);
    steer(-1000, 1);
    steer(3, 4);
    steer(1, 1);
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(-32768, 32767);
    send_sample(32767, -32768);
    send_sample(0, -32768);
    send_sample(-32768, 0);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: thr = 16'd0;
        1: thr = 16'hFFFF;
        2: thr = 16'd1;
        3: thr = 16'd400;
        default: thr = 16'($urandom_range(0, 65535));
      endcase
      set_threshold(thr);
      settings++;
      for (int k = 0; k < PHASE_LEN; k++) begin
        random_sample();
        if ($urandom_range(0, 49) == 0) settle();
      end
      settle();
    end

    repeat (TAIL) @(posedge clk);
    $display("Checked %0d angle requests (%0d held) across %0d threshold settings,",
             samples_seen, held_seen, settings);
    $display("with random gaps and result stalls on both channels.");
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
